### src/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;

  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_TAB  = 8'h09;

  localparam logic [1:0] HEX_LAST  = 2'd3;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESC    = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  // held[2] of a \u run is never read back: the third digit is the current
  // byte whenever the run is cut short, so two entries are kept.
  typedef struct packed {
    mode_t           mode;
    logic [1:0]      hex_cnt;
    logic [7:0]      hex_val;
    logic [1:0][7:0] held;
  } ustate_t;

  // Up to three results produced by one input item.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            vld;
    logic            endf;
  } bundle_t;

  // {hit, mapped byte}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_B:      r = {1'b1, BYTE_BS};
      CH_F:      r = {1'b1, BYTE_FF};
      CH_N:      r = {1'b1, BYTE_LF};
      CH_R:      r = {1'b1, BYTE_CR};
      CH_T:      r = {1'b1, BYTE_TAB};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  // acc*16 + digit, kept to 8 bits; anything but 0-9 and a-f counts as zero
  function automatic logic [7:0] fold_hex(input logic [7:0] acc, input logic [7:0] c);
    logic [3:0] d;
    if (c inside {[CH_0:CH_9]}) begin
      d = c[3:0];
    end else if (c inside {[CH_A:CH_F]}) begin
      d = c[3:0] + 4'd9;
    end else begin
      d = 4'd0;
    end
    return {acc[3:0], d};
  endfunction

endpackage

### src/jsu_skid.sv
`timescale 1ns / 1ps

module jsu_skid (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_data
);

  logic       main_v_r;
  logic [8:0] main_d_r;
  logic       skid_v_r;
  logic [8:0] skid_d_r;
  logic       pop;
  logic       push;

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;
  assign pop       = main_v_r && out_ready;
  assign push      = in_valid && !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_d_r <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_d_r <= in_data;
        main_v_r <= 1'b1;
      end else begin
        skid_d_r <= in_data;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

endmodule

### src/jsu_decode.sv
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::ustate_t st,
  input  logic [7:0]       c,
  input  logic             last,
  output jsu_pkg::ustate_t st_nxt,
  output jsu_pkg::bundle_t res
);
  import jsu_pkg::*;

  logic [8:0]      m_c;
  logic [8:0]      m_h1;
  logic [1:0]      n;
  logic [2:0][7:0] b;

  assign m_c  = esc_map(c);
  assign m_h1 = esc_map(st.held[1]);

  always_comb begin
    st_nxt = st;
    n      = 2'd0;
    b      = '0;
    case (st.mode)
      MODE_ESC: begin
        st_nxt.mode = MODE_NORMAL;
        if (m_c[8]) begin
          b[n] = m_c[7:0];
          n    = n + 2'd1;
        end else if (c == CH_U && !last) begin
          st_nxt.mode    = MODE_HEX;
          st_nxt.hex_cnt = 2'd0;
          st_nxt.hex_val = 8'd0;
        end
      end
      MODE_HEX: begin
        if (st.hex_cnt == HEX_LAST) begin
          b[n]           = fold_hex(st.hex_val, c);
          n              = n + 2'd1;
          st_nxt.mode    = MODE_NORMAL;
          st_nxt.hex_cnt = 2'd0;
          st_nxt.hex_val = 8'd0;
        end else begin
          if (st.hex_cnt == 2'd0) st_nxt.held[0] = c;
          if (st.hex_cnt == 2'd1) st_nxt.held[1] = c;
          st_nxt.hex_val = fold_hex(st.hex_val, c);
          st_nxt.hex_cnt = st.hex_cnt + 2'd1;
          // string cut short: drop \u, decode held digits plus this byte again
          if (last) begin
            if (st.hex_cnt == 2'd0) begin
              b[n] = c;
              n    = n + 2'd1;
            end else if (st.hex_cnt == 2'd1) begin
              if (st.held[0] == CH_BSLASH) begin
                if (m_c[8]) begin
                  b[n] = m_c[7:0];
                  n    = n + 2'd1;
                end
              end else begin
                b[n] = st.held[0];
                n    = n + 2'd1;
                b[n] = c;
                n    = n + 2'd1;
              end
            end else begin
              if (st.held[0] == CH_BSLASH) begin
                if (m_h1[8]) begin
                  b[n] = m_h1[7:0];
                  n    = n + 2'd1;
                end
                b[n] = c;
                n    = n + 2'd1;
              end else begin
                b[n] = st.held[0];
                n    = n + 2'd1;
                if (st.held[1] == CH_BSLASH) begin
                  if (m_c[8]) begin
                    b[n] = m_c[7:0];
                    n    = n + 2'd1;
                  end
                end else begin
                  b[n] = st.held[1];
                  n    = n + 2'd1;
                  b[n] = c;
                  n    = n + 2'd1;
                end
              end
            end
          end
        end
      end
      default: begin
        if (c == CH_BSLASH && !last) begin
          st_nxt.mode = MODE_ESC;
        end else begin
          b[n] = c;
          n    = n + 2'd1;
        end
      end
    endcase

    res.vld  = 1'b1;
    res.endf = last;
    if (last) begin
      // no byte at end of string: bare end marker
      if (n == 2'd0) begin
        n       = 2'd1;
        res.vld = 1'b0;
      end
      st_nxt.mode    = MODE_NORMAL;
      st_nxt.hex_cnt = 2'd0;
      st_nxt.hex_val = 8'd0;
    end
    res.cnt   = n;
    res.bytes = b;
  end

endmodule

### src/json_string_unescape_top.sv
// Accepted items pass the input buffer, then are decoded into the result buffer.
// Throughput: one item per cycle with out_tready high; the k results of an item
// (k up to 3, only when a string ends inside \u) hold the result buffer until sent.
// Reset: synchronous, active low; clears the input buffer, the result buffer and
// the escape state (normal mode, no \u digits pending).
`timescale 1ns / 1ps

module json_string_unescape_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] out_valid
  output logic       out_tlast
);
  import jsu_pkg::*;

  logic       f_valid;
  logic       f_ready;
  logic [8:0] f_data;
  logic       take;
  logic       out_take;
  logic       drain_done;

  ustate_t    st_r;
  ustate_t    st_nxt;
  bundle_t    dec;
  bundle_t    bun_r;
  logic [1:0] idx_r;

  jsu_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   ({in_tlast, in_tdata}),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  jsu_decode u_decode (
    .st     (st_r),
    .c      (f_data[7:0]),
    .last   (f_data[8]),
    .st_nxt (st_nxt),
    .res    (dec)
  );

  assign out_tvalid = (bun_r.cnt != 2'd0);
  assign out_tdata  = bun_r.bytes[idx_r];
  assign out_tuser  = bun_r.vld;
  assign out_tlast  = bun_r.endf && (idx_r == bun_r.cnt - 2'd1);

  assign out_take   = out_tvalid && out_tready;
  assign drain_done = out_take && (idx_r == bun_r.cnt - 2'd1);
  assign f_ready    = (bun_r.cnt == 2'd0) || drain_done;
  assign take       = f_valid && f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode    <= MODE_NORMAL;
      st_r.hex_cnt <= 2'd0;
      st_r.hex_val <= 8'd0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bun_r.cnt <= 2'd0;
      idx_r     <= 2'd0;
    end else if (take) begin
      bun_r <= dec;
      idx_r <= 2'd0;
    end else if (drain_done) begin
      bun_r.cnt <= 2'd0;
      idx_r     <= 2'd0;
    end else if (out_take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bun_r.cnt != 2'd0) |-> (idx_r < bun_r.cnt))
    else $error("result index beyond buffered count");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && bun_r.cnt == 2'd1 && out_tdata == 8'd0))
    else $error("bare end marker malformed");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && f_data[8]) |=> (st_r.mode == MODE_NORMAL && st_r.hex_cnt == 2'd0
                             && st_r.hex_val == 8'd0))
    else $error("escape state not cleared at end of string");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && st_r.mode != MODE_HEX) |=> (bun_r.cnt == 2'd0 || bun_r.cnt == 2'd1))
    else $error("multi-result bundle outside a \\u run");

endmodule
